/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define TGM_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// property checked on every rising edge, reset included
`define TGM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TGM_ASSERT(label, clk, rstn, prop, msg)
`define TGM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/tgm_pkg.sv */
// ----------------------------------------------------------------------------
// tgm_pkg
// shared types and constants of the touch gesture to mouse translator
// ----------------------------------------------------------------------------
package tgm_pkg;

  // field widths
  localparam int CoordBitsDef  = 12;
  localparam int CountBits     = 2;
  localparam int TimeBits      = 32;
  localparam int TravelBits    = 16;
  localparam int StepBits      = 8;
  localparam int TapMsBits     = 16;
  localparam int TravelCfgBits = 12;
  localparam int WheelLimBits  = 7;
  localparam int CfgIdxBits    = 3;
  localparam int CfgDataBits   = 16;

  // acceleration: a + a*a/16, capped at 127
  localparam int AccelShift   = 4;
  localparam int AccelLinBits = 6;
  localparam int AccelMagBits = 7;
  localparam logic [AccelMagBits-1:0] AccelMax = 7'd127;

  // wheel step is the midpoint change divided by four
  localparam int WheelShift = 2;

  // finger counts
  localparam logic [CountBits-1:0] CntZero = 2'd0;
  localparam logic [CountBits-1:0] CntOne  = 2'd1;
  localparam logic [CountBits-1:0] CntTwo  = 2'd2;
  localparam logic [CountBits-1:0] CntSat  = 2'd3;

  // register reset values
  localparam logic [TapMsBits-1:0]     TapMaxMsRst     = 16'd280;
  localparam logic [TravelCfgBits-1:0] TapMaxTravelRst = 12'd12;
  localparam logic [TravelCfgBits-1:0] MoveStartRst    = 12'd4;
  localparam logic [TravelCfgBits-1:0] ScrollStartRst  = 12'd6;
  localparam logic [WheelLimBits-1:0]  WheelLimitRst   = 7'd8;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_MOVING    = 2'd1,
    PH_SCROLLING = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_LEFT   = 3'd1,
    EV_RIGHT  = 3'd2,
    EV_MOVE   = 3'd3,
    EV_SCROLL = 3'd4
  } event_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_TAP_MAX_MS     = 3'd0,
    CFG_TAP_MAX_TRAVEL = 3'd1,
    CFG_MOVE_START     = 3'd2,
    CFG_SCROLL_START   = 3'd3,
    CFG_WHEEL_LIMIT    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TapMsBits-1:0]     tap_max_ms;
    logic [TravelCfgBits-1:0] tap_max_travel;
    logic [TravelCfgBits-1:0] move_start;
    logic [TravelCfgBits-1:0] scroll_start;
    logic [WheelLimBits-1:0]  wheel_limit;
  } cfg_t;

  // session state that does not depend on the coordinate width
  typedef struct packed {
    phase_e                phase;
    logic [CountBits-1:0]  prev_count;
    logic [CountBits-1:0]  peak_count;
    logic [TimeBits-1:0]   session_start;
    logic [TravelBits-1:0] travel_sum;
  } ctl_state_t;

  typedef struct packed {
    event_e                     kind;
    logic signed [StepBits-1:0] move_x;
    logic signed [StepBits-1:0] move_y;
    logic signed [StepBits-1:0] wheel;
  } result_t;

endpackage

/* rtl/touch_gesture_to_mouse.sv */
// ----------------------------------------------------------------------------
// touch_gesture_to_mouse
// turns touch polls into left/right clicks, accelerated moves and wheel steps
//
//   channel   handshake                  payload
//   in        in_valid_i / in_ready_o    link_up, finger_count, coords, time
//   out       out_valid_o / out_ready_i  event_kind, move_x, move_y, wheel
//   cfg       cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// one item per cycle sustained while out_ready_i stays high
// the poll register feeds the step logic, which writes the session state and
// the result register in the same cycle, so each item passes poll then result register
// a stalled result holds the result register; an empty poll register still takes
// one item, then in_ready_o drops until the result is taken
// reset clears the session state, loads register defaults, empties both stages
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_gesture_to_mouse
  import tgm_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [CfgDataBits-1:0]     cfg_wdata_i,
  // touch polls
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       link_up_i,
  input  logic [CountBits-1:0]       finger_count_i,
  input  logic [COORD_BITS-1:0]      first_x_i,
  input  logic [COORD_BITS-1:0]      first_y_i,
  input  logic [COORD_BITS-1:0]      second_y_i,
  input  logic [TimeBits-1:0]        time_ms_i,
  // mouse events
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 event_kind_o,
  output logic signed [StepBits-1:0] move_x_o,
  output logic signed [StepBits-1:0] move_y_o,
  output logic signed [StepBits-1:0] wheel_step_o
);

  cfg_t cfg;

  // poll register
  logic                  in_vld_q, in_vld_d;
  logic                  link_q;
  logic [CountBits-1:0]  count_q;
  logic [COORD_BITS-1:0] x_q, y_q, y2_q;
  logic [TimeBits-1:0]   time_q;

  // session state
  ctl_state_t            ctl_q, ctl_d;
  logic [COORD_BITS-1:0] ref_x_q, ref_x_d, ref_y_q, ref_y_d, mid_y_q, mid_y_d;

  // result register
  logic                  out_vld_q, out_vld_d;
  result_t               res_q, res_d;

  logic                  in_fire, adv;

  tgm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tgm_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .link_i  (link_q),
    .count_i (count_q),
    .x_i     (x_q),
    .y_i     (y_q),
    .y2_i    (y2_q),
    .time_i  (time_q),
    .cfg_i   (cfg),
    .st_i    (ctl_q),
    .ref_x_i (ref_x_q),
    .ref_y_i (ref_y_q),
    .mid_y_i (mid_y_q),
    .st_o    (ctl_d),
    .ref_x_o (ref_x_d),
    .ref_y_o (ref_y_d),
    .mid_y_o (mid_y_d),
    .res_o   (res_d)
  );

  // stage control: the poll moves on when the result register is free
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // control and session registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ctl_q     <= '0;
      ref_x_q   <= '0;
      ref_y_q   <= '0;
      mid_y_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        ctl_q   <= ctl_d;
        ref_x_q <= ref_x_d;
        ref_y_q <= ref_y_d;
        mid_y_q <= mid_y_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      link_q  <= link_up_i;
      count_q <= finger_count_i;
      x_q     <= first_x_i;
      y_q     <= first_y_i;
      y2_q    <= second_y_i;
      time_q  <= time_ms_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_kind_o = res_q.kind;
  assign move_x_o     = res_q.move_x;
  assign move_y_o     = res_q.move_y;
  assign wheel_step_o = res_q.wheel;

  // checks
  `TGM_ASSERT(a_phase_needs_fingers, clk_i, rst_ni, (ctl_q.phase != PH_IDLE) |-> (ctl_q.prev_count != CntZero), "active phase with no fingers down")
  `TGM_ASSERT(a_peak_tracks_prev, clk_i, rst_ni, (ctl_q.prev_count != CntZero) |-> (ctl_q.peak_count != CntZero), "fingers down but peak count is zero")
  `TGM_ASSERT(a_state_holds, clk_i, rst_ni, !adv |=> ($stable(ctl_q) && $stable(mid_y_q)), "session state changed without an item")
  `TGM_ASSERT(a_move_nonzero, clk_i, rst_ni, (out_vld_q && res_q.kind == EV_MOVE) |-> (res_q.move_x != '0 || res_q.move_y != '0), "move event with no motion")
  `TGM_ASSERT(a_scroll_nonzero, clk_i, rst_ni, (out_vld_q && res_q.kind == EV_SCROLL) |-> (res_q.wheel != '0 && res_q.move_x == '0), "bad scroll event")
  `TGM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_vld_q, "result valid right after reset")

endmodule

/* rtl/tgm_cfg.sv */
// ----------------------------------------------------------------------------
// tgm_cfg
// configuration registers, written through a plain indexed write port
// ----------------------------------------------------------------------------
module tgm_cfg
  import tgm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TAP_MAX_MS:     cfg_d.tap_max_ms     = cfg_wdata_i[TapMsBits-1:0];
        CFG_TAP_MAX_TRAVEL: cfg_d.tap_max_travel = cfg_wdata_i[TravelCfgBits-1:0];
        CFG_MOVE_START:     cfg_d.move_start     = cfg_wdata_i[TravelCfgBits-1:0];
        CFG_SCROLL_START:   cfg_d.scroll_start   = cfg_wdata_i[TravelCfgBits-1:0];
        CFG_WHEEL_LIMIT:    cfg_d.wheel_limit    = cfg_wdata_i[WheelLimBits-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_max_ms     <= TapMaxMsRst;
      cfg_q.tap_max_travel <= TapMaxTravelRst;
      cfg_q.move_start     <= MoveStartRst;
      cfg_q.scroll_start   <= ScrollStartRst;
      cfg_q.wheel_limit    <= WheelLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/tgm_step.sv */
// ----------------------------------------------------------------------------
// tgm_step
// one poll of gesture decoding: next session state and the mouse event
// ----------------------------------------------------------------------------
module tgm_step
  import tgm_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                  link_i,
  input  logic [CountBits-1:0]  count_i,
  input  logic [COORD_BITS-1:0] x_i,
  input  logic [COORD_BITS-1:0] y_i,
  input  logic [COORD_BITS-1:0] y2_i,
  input  logic [TimeBits-1:0]   time_i,
  input  cfg_t                  cfg_i,
  input  ctl_state_t            st_i,
  input  logic [COORD_BITS-1:0] ref_x_i,
  input  logic [COORD_BITS-1:0] ref_y_i,
  input  logic [COORD_BITS-1:0] mid_y_i,
  output ctl_state_t            st_o,
  output logic [COORD_BITS-1:0] ref_x_o,
  output logic [COORD_BITS-1:0] ref_y_o,
  output logic [COORD_BITS-1:0] mid_y_o,
  output result_t               res_o
);

  localparam int SumBits  = TravelBits + 2;
  localparam int WmagBits = COORD_BITS - WheelShift;
  localparam int CmpBits  = COORD_BITS + WheelLimBits;

  // signed magnitude a becomes a + a*a/16, capped, sign kept
  function automatic logic [StepBits-1:0] speed_up(input logic signed [COORD_BITS:0] d);
    logic signed [COORD_BITS:0] nd;
    logic [COORD_BITS-1:0]      a;
    logic [AccelLinBits-1:0]    lo;
    logic [2*AccelLinBits-1:0]  sq;
    logic [AccelLinBits+2:0]    o;
    logic                       big;
    logic [AccelMagBits-1:0]    mag;
    nd  = -d;
    a   = d[COORD_BITS] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    lo  = a[AccelLinBits-1:0];
    big = (a[COORD_BITS-1:AccelLinBits] != '0);
    sq  = lo * lo;
    o   = (AccelLinBits+3)'(lo) + (AccelLinBits+3)'(sq[2*AccelLinBits-1:AccelShift]);
    mag = (big || o > (AccelLinBits+3)'(AccelMax)) ? AccelMax : o[AccelMagBits-1:0];
    return d[COORD_BITS] ? (StepBits'(0) - StepBits'(mag)) : StepBits'(mag);
  endfunction

  logic [CountBits-1:0]        n;
  logic                        fresh;
  logic [COORD_BITS:0]         ysum;
  logic [COORD_BITS-1:0]       mid_now;
  logic [TimeBits-1:0]         dur;
  logic signed [COORD_BITS:0]  dx, dy, ndx, ndy, wdy, nwdy;
  logic [COORD_BITS-1:0]       adx, ady, awdy;
  logic [SumBits-1:0]          tsum;
  logic [TravelBits-1:0]       travel_n;
  logic [WmagBits-1:0]         wmag;
  logic [CmpBits-1:0]          wmag_ext, lim_ext;
  logic [WheelLimBits-1:0]     wclamp;

  // vertical midpoint (y only) of the two fingers
  assign ysum    = {1'b0, x_i} - {1'b0, x_i} + {1'b0, y_i} + {1'b0, y2_i};
  assign mid_now = ysum[COORD_BITS:1];

  // session update and event selection, in poll order
  always_comb begin
    st_o     = st_i;
    ref_x_o  = ref_x_i;
    ref_y_o  = ref_y_i;
    mid_y_o  = mid_y_i;
    res_o    = '0;
    n        = (count_i == CntSat) ? CntTwo : count_i;
    fresh    = (st_i.prev_count == CntZero);
    dur      = time_i - st_i.session_start;
    dx       = '0;
    dy       = '0;
    ndx      = '0;
    ndy      = '0;
    adx      = '0;
    ady      = '0;
    wdy      = '0;
    nwdy     = '0;
    awdy     = '0;
    tsum     = '0;
    travel_n = '0;
    wmag     = '0;
    wmag_ext = '0;
    lim_ext  = '0;
    wclamp   = '0;

    if (!link_i) begin
      // link loss ends the session silently
      st_o.phase      = PH_IDLE;
      st_o.peak_count = CntZero;
      st_o.travel_sum = '0;
      st_o.prev_count = CntZero;
    end else begin
      // fingers landing
      if (n > st_i.prev_count) begin
        if (fresh) begin
          st_o.session_start = time_i;
          st_o.travel_sum    = '0;
          st_o.peak_count    = n;
          ref_x_o            = x_i;
          ref_y_o            = y_i;
          st_o.phase         = PH_IDLE;
        end
        if (n == CntTwo && (st_o.peak_count < CntTwo || fresh)) begin
          st_o.peak_count = CntTwo;
          mid_y_o         = mid_now;
          st_o.phase      = PH_IDLE;
        end
      end else if (n == CntZero && st_i.prev_count != CntZero) begin
        // all fingers lifted: short still session is a click
        if (dur < TimeBits'(cfg_i.tap_max_ms) &&
            st_i.travel_sum < TravelBits'(cfg_i.tap_max_travel)) begin
          case (st_i.peak_count)
            CntOne:  res_o.kind = EV_LEFT;
            CntTwo:  res_o.kind = EV_RIGHT;
            default: res_o.kind = EV_NONE;
          endcase
        end
        st_o.phase      = PH_IDLE;
        st_o.peak_count = CntZero;
        st_o.travel_sum = '0;
      end

      if (n == CntOne && st_o.peak_count == CntOne) begin
        // one-finger pointer motion
        dx   = $signed({1'b0, x_i}) - $signed({1'b0, ref_x_o});
        dy   = $signed({1'b0, y_i}) - $signed({1'b0, ref_y_o});
        ndx  = -dx;
        ndy  = -dy;
        adx  = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady  = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        ref_x_o = x_i;
        ref_y_o = y_i;
        tsum = SumBits'(st_o.travel_sum) + SumBits'(adx) + SumBits'(ady);
        travel_n = (tsum[SumBits-1:TravelBits] != '0) ? '1 : tsum[TravelBits-1:0];
        st_o.travel_sum = travel_n;
        if (travel_n >= TravelBits'(cfg_i.move_start) || st_o.phase == PH_MOVING) begin
          st_o.phase = PH_MOVING;
          if (dx != '0 || dy != '0) begin
            res_o.kind   = EV_MOVE;
            res_o.move_x = speed_up(dx);
            res_o.move_y = speed_up(dy);
          end
        end
      end else if (n == CntTwo) begin
        // two-finger wheel motion
        wdy  = $signed({1'b0, mid_now}) - $signed({1'b0, mid_y_o});
        nwdy = -wdy;
        awdy = wdy[COORD_BITS] ? nwdy[COORD_BITS-1:0] : wdy[COORD_BITS-1:0];
        mid_y_o = mid_now;
        tsum = SumBits'(st_o.travel_sum) + SumBits'(awdy);
        travel_n = (tsum[SumBits-1:TravelBits] != '0) ? '1 : tsum[TravelBits-1:0];
        st_o.travel_sum = travel_n;
        if (travel_n >= TravelBits'(cfg_i.scroll_start) ||
            st_o.phase == PH_SCROLLING) begin
          st_o.phase = PH_SCROLLING;
          wmag     = awdy[COORD_BITS-1:WheelShift];
          wmag_ext = CmpBits'(wmag);
          lim_ext  = CmpBits'(cfg_i.wheel_limit);
          wclamp   = (wmag_ext > lim_ext) ? cfg_i.wheel_limit
                                          : wmag_ext[WheelLimBits-1:0];
          if (wclamp != '0) begin
            res_o.kind  = EV_SCROLL;
            // upward finger motion (negative change) scrolls up
            res_o.wheel = wdy[COORD_BITS] ? StepBits'(wclamp)
                                          : (StepBits'(0) - StepBits'(wclamp));
          end
        end
      end

      st_o.prev_count = n;
    end
  end

endmodule
